### design/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FCL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fcl port check failed");

// Next-cycle implication, disabled while reset is low.
`define FCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fcl port check failed");

// Next-cycle implication that also watches the reset cycles themselves.
`define FCL_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("fcl reset check failed");

`endif

### design/fcl_pkg.sv
`timescale 1ns / 1ps
package fcl_pkg;

    localparam int MAX_INPUTS_DEFAULT  = 1024;
    localparam int MAX_OUTPUTS_DEFAULT = 1024;

    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 10;
    localparam int ACC_W       = 32;
    localparam int SHIFT_W     = 5;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic OP_FEATURE = 1'b0;
    localparam logic OP_WEIGHT  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INPUT_COUNT  = 2'd0,
        CFG_OUTPUT_COUNT = 2'd1,
        CFG_RESULT_SHIFT = 2'd2
    } cfg_index_t;

    // One command from the front to the back. A non-MAC command writes the
    // sample into the feature store.
    typedef struct packed {
        logic                       mac;
        logic                       first;
        logic                       row_end;
        logic                       layer_last;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] bias;
    } fcl_cmd_t;

endpackage

### design/fixed_fully_connected_layer.sv
`timescale 1ns / 1ps
// 16-bit fixed-point fully connected layer.
// Input channel (s_*): one beat per feature (s_op = 0) or weight (s_op = 1).
//   Features fill the feature store in order; extra features are dropped.
//   Weights stream row by row; s_bias is taken on the last weight of a row.
// Result channel (m_*): one beat per row with the shifted dot product plus
//   bias (16-bit wrap), the row index and m_last on the final row.
// Config port: cfg_we/cfg_index/cfg_data, written while the block is idle;
//   a write to one of the three registers restarts the layer (features kept).
// Throughput: one beat per cycle (features or weights) while queue has room.
// Path: a row's last weight reaches m_* from its beat through the command
//   queue, the feature store read port, the multiplier register, the
//   accumulator and the output register.
// Reset (aresetn low, synchronous): counters clear, input_count and
//   output_count return to 1, result_shift to 0. The feature store is not
//   cleared: a weight must not read a feature that was never loaded.
// Stall: a result waiting on m_ready holds and the back end freezes;
//   the front keeps taking beats until the 4-entry command queue fills.
module fixed_fully_connected_layer
    import fcl_pkg::*;
#(
    parameter int MAX_INPUTS  = MAX_INPUTS_DEFAULT,
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic signed [SAMPLE_W-1:0] s_bias,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_out_value,
    output logic [INDEX_W-1:0]         m_out_index,
    output logic                       m_last,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    // feature store address width
    localparam int FAW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int QDW   = FAW + $bits(fcl_cmd_t);

    // front -> queue
    logic               fq_valid, fq_ready;
    logic [FAW-1:0]     fq_addr;
    fcl_cmd_t           fq_cmd;

    // queue -> back
    logic               qb_valid, qb_ready;
    logic [QDW-1:0]     qb_data;
    logic [FAW-1:0]     qb_addr;
    fcl_cmd_t           qb_cmd;

    logic [SHIFT_W-1:0] result_shift;

    // Front: accept beats, track feature/weight/row positions, classify.
    fcl_front #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_sample     (s_sample),
        .s_bias       (s_bias),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_addr       (fq_addr),
        .q_cmd        (fq_cmd),
        .result_shift (result_shift)
    );

    // Short queue: lets the front keep going while the result side stalls.
    fcl_queue #(
        .DATA_W (QDW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_addr, fq_cmd}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    assign {qb_addr, qb_cmd} = qb_data;

    // Back: feature store, multiply-accumulate, scale and bias, output beat.
    fcl_back #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_addr       (qb_addr),
        .q_cmd        (qb_cmd),
        .result_shift (result_shift),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_out_index  (m_out_index),
        .m_last       (m_last)
    );

endmodule

### design/fcl_queue.sv
`timescale 1ns / 1ps
module fcl_queue
    import fcl_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### design/fcl_front.sv
`timescale 1ns / 1ps
module fcl_front
    import fcl_pkg::*;
#(
    parameter int MAX_INPUTS  = MAX_INPUTS_DEFAULT,
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEFAULT,
    localparam int FAW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic signed [SAMPLE_W-1:0] s_bias,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output logic                       q_valid,
    input  logic                       q_ready,
    output logic [FAW-1:0]             q_addr,
    output fcl_cmd_t                   q_cmd,
    output logic [SHIFT_W-1:0]         result_shift
);

    localparam int CIW = $clog2(MAX_INPUTS + 1);
    localparam int COW = $clog2(MAX_OUTPUTS + 1);
    localparam int RW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    logic [CIW-1:0]     in_count_reg;
    logic [COW-1:0]     out_count_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [CIW-1:0]     loaded_reg;
    logic [FAW-1:0]     wpos_reg;
    logic [RW-1:0]      row_reg;

    logic           accept;
    logic           is_weight;
    logic           room;
    logic           row_end;
    logic           layer_last;
    logic [CIW-1:0] in_eff;
    logic [COW-1:0] out_eff;

    assign s_ready      = q_ready;
    assign accept       = s_valid && s_ready;
    assign is_weight    = (s_op == OP_WEIGHT);
    assign room         = (loaded_reg < in_count_reg);
    assign row_end      = ((CIW'(wpos_reg) + CIW'(1)) == in_count_reg);
    assign layer_last   = ((COW'(row_reg) + COW'(1)) == out_count_reg);
    assign result_shift = shift_reg;

    // Zero counts act as one, oversized counts saturate at MAX_INPUTS / MAX_OUTPUTS.
    always_comb begin
        if (cfg_data == '0) begin
            in_eff  = CIW'(1);
            out_eff = COW'(1);
        end else begin
            in_eff  = (int'(cfg_data) > MAX_INPUTS) ? CIW'(MAX_INPUTS) : CIW'(cfg_data);
            out_eff = (int'(cfg_data) > MAX_OUTPUTS) ? COW'(MAX_OUTPUTS) : COW'(cfg_data);
        end
    end

    // Dropped features (configured count already loaded) are accepted without a command.
    assign q_valid = s_valid && (is_weight || room);
    assign q_addr  = is_weight ? wpos_reg : loaded_reg[FAW-1:0];

    always_comb begin
        q_cmd            = '0;
        q_cmd.mac        = is_weight;
        q_cmd.first      = (wpos_reg == '0);
        q_cmd.row_end    = row_end;
        q_cmd.layer_last = layer_last;
        q_cmd.index      = INDEX_W'(row_reg);
        q_cmd.sample     = s_sample;
        q_cmd.bias       = s_bias;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_count_reg  <= CIW'(1);
            out_count_reg <= COW'(1);
            shift_reg     <= '0;
            loaded_reg    <= '0;
            wpos_reg      <= '0;
            row_reg       <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_INPUT_COUNT: begin
                    in_count_reg <= in_eff;
                    loaded_reg   <= '0;
                    wpos_reg     <= '0;
                    row_reg      <= '0;
                end
                CFG_OUTPUT_COUNT: begin
                    out_count_reg <= out_eff;
                    loaded_reg    <= '0;
                    wpos_reg      <= '0;
                    row_reg       <= '0;
                end
                CFG_RESULT_SHIFT: begin
                    shift_reg  <= cfg_data[SHIFT_W-1:0];
                    loaded_reg <= '0;
                    wpos_reg   <= '0;
                    row_reg    <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (!is_weight) begin
                if (room) begin
                    loaded_reg <= loaded_reg + CIW'(1);
                end
            end else if (row_end) begin
                wpos_reg <= '0;
                if (layer_last) begin
                    row_reg    <= '0;
                    loaded_reg <= '0;
                end else begin
                    row_reg <= row_reg + RW'(1);
                end
            end else begin
                wpos_reg <= wpos_reg + FAW'(1);
            end
        end
    end

endmodule

### design/fcl_back.sv
`timescale 1ns / 1ps
module fcl_back
    import fcl_pkg::*;
#(
    parameter int MAX_INPUTS = MAX_INPUTS_DEFAULT,
    localparam int FAW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  logic [FAW-1:0]             q_addr,
    input  fcl_cmd_t                   q_cmd,
    input  logic [SHIFT_W-1:0]         result_shift,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_out_value,
    output logic [INDEX_W-1:0]         m_out_index,
    output logic                       m_last
);

    logic signed [SAMPLE_W-1:0] feat_mem [MAX_INPUTS];

    logic                       adv;
    logic                       pop;

    // read stage
    logic                       s1_valid_reg;
    logic                       s1_first_reg, s1_end_reg, s1_last_reg;
    logic [INDEX_W-1:0]         s1_index_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg, s1_bias_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    // multiply stage
    logic                       s2_valid_reg;
    logic                       s2_first_reg, s2_end_reg, s2_last_reg;
    logic [INDEX_W-1:0]         s2_index_reg;
    logic signed [SAMPLE_W-1:0] s2_bias_reg;
    logic signed [ACC_W-1:0]    prod_reg;

    // accumulate stage
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       fin_valid_reg;
    logic                       fin_last_reg;
    logic [INDEX_W-1:0]         fin_index_reg;
    logic signed [SAMPLE_W-1:0] fin_bias_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg, out_value_next;
    logic [INDEX_W-1:0]         out_index_reg;
    logic                       out_last_reg;
    logic signed [ACC_W-1:0]    shifted;

    assign adv     = !out_valid_reg || m_ready;
    assign q_ready = adv;
    assign pop     = q_valid && adv;

    assign shifted        = acc_reg >>> result_shift;
    assign out_value_next = shifted[SAMPLE_W-1:0] + fin_bias_reg;

    assign m_valid     = out_valid_reg;
    assign m_out_value = out_value_reg;
    assign m_out_index = out_index_reg;
    assign m_last      = out_last_reg;

    always_ff @(posedge aclk) begin
        if (pop && !q_cmd.mac) begin
            feat_mem[q_addr] <= q_cmd.sample;
        end
        if (pop) begin
            rd_data_reg <= feat_mem[q_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= pop && q_cmd.mac;
            s2_valid_reg  <= s1_valid_reg;
            fin_valid_reg <= s2_valid_reg && s2_end_reg;
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_first_reg  <= q_cmd.first;
            s1_end_reg    <= q_cmd.row_end;
            s1_last_reg   <= q_cmd.layer_last;
            s1_index_reg  <= q_cmd.index;
            s1_sample_reg <= q_cmd.sample;
            s1_bias_reg   <= q_cmd.bias;

            s2_first_reg  <= s1_first_reg;
            s2_end_reg    <= s1_end_reg;
            s2_last_reg   <= s1_last_reg;
            s2_index_reg  <= s1_index_reg;
            s2_bias_reg   <= s1_bias_reg;
            prod_reg      <= s1_sample_reg * rd_data_reg;

            if (s2_valid_reg) begin
                acc_reg <= (s2_first_reg ? '0 : acc_reg) + prod_reg;
            end
            fin_last_reg  <= s2_last_reg;
            fin_index_reg <= s2_index_reg;
            fin_bias_reg  <= s2_bias_reg;

            if (fin_valid_reg) begin
                out_value_reg <= out_value_next;
                out_index_reg <= fin_index_reg;
                out_last_reg  <= fin_last_reg;
            end
        end
    end

endmodule

### design/fcl_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcl_port_checker
    import fcl_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SAMPLE_W-1:0] m_out_value,
    input logic [INDEX_W-1:0]         m_out_index,
    input logic                       m_last
);

    // stalled result beat holds
    `FCL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)
    `FCL_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable({m_out_value, m_out_index, m_last}))

    // empty queue after reset: input side open at once
    `FCL_ASSERT_RESET(a_reset_ready, !aresetn, s_ready)

    // after reset, m_valid stays low until a result has passed the pipeline
    `FCL_ASSERT_RESET(a_reset_quiet, !aresetn, !m_valid ##1 !m_valid ##1 !m_valid ##1 !m_valid)

    // a result beat never carries unknown bits
    `FCL_ASSERT_IMPL(a_out_known, m_valid, !$isunknown({m_out_value, m_out_index, m_last}))

endmodule

bind fixed_fully_connected_layer fcl_port_checker u_fcl_checker (.*);

### verif/fcl_checker.sv
`timescale 1ns / 1ps
// Watches both channels and the config port of the fully connected layer,
// predicts one output unit per finished row and compares it on the m_ side.
module fcl_checker
    import fcl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_op,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic signed [SAMPLE_W-1:0] s_bias,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_out_value,
    input  logic [INDEX_W-1:0]         m_out_index,
    input  logic                       m_last,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         mismatches,
    output int                         pending
);

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic [INDEX_W-1:0]         index;
        logic                       last;
    } unit_out_t;

    logic signed [SAMPLE_W-1:0] feat_mem [0:MAX_INPUTS_DEFAULT-1];
    logic signed [ACC_W-1:0]    dot_acc;
    logic [CFG_DATA_W-1:0]      num_inputs_reg;
    logic [CFG_DATA_W-1:0]      num_units_reg;
    logic [SHIFT_W-1:0]         shift_reg;
    int unsigned                feat_cnt;
    int unsigned                tap_pos;
    int unsigned                unit_num;
    unit_out_t                  unit_q[$];

    initial begin
        mismatches = 0;
        pending    = 0;
        for (int i = 0; i < MAX_INPUTS_DEFAULT; i++) feat_mem[i] = '0;
    end

    task automatic report(input string field, input int want, input int got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin : watch
        int unsigned             n_in;
        int unsigned             n_out;
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] scaled;
        unit_out_t               unit;

        if (!aresetn) begin
            dot_acc        = '0;
            feat_cnt       = 0;
            tap_pos        = 0;
            unit_num       = 0;
            num_inputs_reg = 1;
            num_units_reg  = 1;
            shift_reg      = 0;
            unit_q.delete();
        end else begin
            // Any register write restarts the layer; stored features stay.
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_INPUT_COUNT:  num_inputs_reg = cfg_data;
                    CFG_OUTPUT_COUNT: num_units_reg  = cfg_data;
                    CFG_RESULT_SHIFT: shift_reg      = cfg_data[SHIFT_W-1:0];
                    default:          ;
                endcase
                if (cfg_index_t'(cfg_index) inside {CFG_INPUT_COUNT, CFG_OUTPUT_COUNT,
                                                     CFG_RESULT_SHIFT}) begin
                    dot_acc  = '0;
                    feat_cnt = 0;
                    tap_pos  = 0;
                    unit_num = 0;
                end
            end

            n_in  = (num_inputs_reg == 0) ? 1 :
                    (num_inputs_reg > MAX_INPUTS_DEFAULT) ? MAX_INPUTS_DEFAULT : num_inputs_reg;
            n_out = (num_units_reg == 0) ? 1 :
                    (num_units_reg > MAX_OUTPUTS_DEFAULT) ? MAX_OUTPUTS_DEFAULT : num_units_reg;

            if (s_valid && s_ready) begin
                if (s_op == OP_FEATURE) begin
                    // drop features beyond the configured count
                    if (feat_cnt < n_in) begin
                        feat_mem[feat_cnt] = s_sample;
                        feat_cnt++;
                    end
                end else begin
                    if (tap_pos >= n_in) tap_pos = 0;
                    prod    = s_sample * feat_mem[tap_pos];
                    dot_acc = dot_acc + prod;
                    if (tap_pos + 1 < n_in) begin
                        tap_pos++;
                    end else begin
                        scaled     = dot_acc >>> shift_reg;
                        unit.value = scaled[SAMPLE_W-1:0] + s_bias;
                        if (unit_num >= n_out) unit_num = 0;
                        unit.index = unit_num[INDEX_W-1:0];
                        unit.last  = (unit_num + 1 == n_out);
                        unit_q.push_back(unit);
                        dot_acc = '0;
                        tap_pos = 0;
                        if (unit.last) begin
                            unit_num = 0;
                            feat_cnt = 0;
                        end else begin
                            unit_num++;
                        end
                    end
                end
            end

            if (m_valid && m_ready) begin
                if (unit_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected output beat, value %0d index %0d last %0d",
                             $time, m_out_value, m_out_index, m_last);
                end else begin
                    unit = unit_q.pop_front();
                    if (m_out_value !== unit.value) report("out_value", unit.value, m_out_value);
                    if (m_out_index !== unit.index) report("out_index", unit.index, m_out_index);
                    if (m_last !== unit.last) report("last", unit.last, m_last);
                end
            end
        end
        pending <= unit_q.size();
    end

endmodule

### verif/tb_fixed_fully_connected_layer.sv
`timescale 1ns / 1ps
module tb_fixed_fully_connected_layer;
    import fcl_pkg::*;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic                       s_op        = OP_FEATURE;
    logic signed [SAMPLE_W-1:0] s_sample    = '0;
    logic signed [SAMPLE_W-1:0] s_bias      = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_value;
    logic [INDEX_W-1:0]         m_out_index;
    logic                       m_last;
    logic                       cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index   = CFG_INPUT_COUNT;
    logic [CFG_DATA_W-1:0]      cfg_data    = '0;

    int mismatches;
    int pending;

    // Percent of cycles in which each side holds off.
    int tx_idle_pct = 38;
    int rx_idle_pct = 53;

    // Stimulus bookkeeping: effective layer shape and how many feature
    // entries have ever been written (entries 0 .. stored_hi-1).
    int unsigned eff_in     = 1;
    int unsigned eff_out    = 1;
    int unsigned stored_hi  = 0;
    int unsigned items_sent = 0;

    always #2 aclk = ~aclk;

    fixed_fully_connected_layer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_sample    (s_sample),
        .s_bias      (s_bias),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value),
        .m_out_index (m_out_index),
        .m_last      (m_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    fcl_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_sample    (s_sample),
        .s_bias      (s_bias),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value),
        .m_out_index (m_out_index),
        .m_last      (m_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Receiver: drop ready at random, one decision per cycle.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #(2_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // Mostly random samples, with the extremes and small values mixed in.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return SAMPLE_W'(int'($urandom_range(16)) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Present one beat and hold it until accepted. Enter and leave at a
    // falling edge; valid stays high on exit so back-to-back beats need no gap.
    task automatic send_beat(input logic op, input logic signed [SAMPLE_W-1:0] sample,
                             input logic signed [SAMPLE_W-1:0] bias);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_sample <= sample;
        s_bias   <= bias;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Drop valid, wait until every expected unit has come out, then let the
    // pipeline flush with the receiver ready.
    task automatic settle();
        int n;
        n = 0;
        s_valid <= 1'b0;
        while (n < 8) begin
            @(negedge aclk);
            if (pending == 0 && m_ready) n++;
        end
    endtask

    // Write all three registers on consecutive cycles (the block is idle).
    task automatic program_layer(input int unsigned num_in, input int unsigned num_out,
                                 input int unsigned shift);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INPUT_COUNT;
        cfg_data  <= CFG_DATA_W'(num_in);
        @(negedge aclk);
        cfg_index <= CFG_OUTPUT_COUNT;
        cfg_data  <= CFG_DATA_W'(num_out);
        @(negedge aclk);
        cfg_index <= CFG_RESULT_SHIFT;
        cfg_data  <= CFG_DATA_W'(shift);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        num_in  = num_in % (1 << CFG_DATA_W);
        num_out = num_out % (1 << CFG_DATA_W);
        eff_in  = (num_in == 0) ? 1 :
                  (num_in > MAX_INPUTS_DEFAULT) ? MAX_INPUTS_DEFAULT : num_in;
        eff_out = (num_out == 0) ? 1 :
                  (num_out > MAX_OUTPUTS_DEFAULT) ? MAX_OUTPUTS_DEFAULT : num_out;
    endtask

    // One layer: features, then every row of weights. Sometimes reuse stale
    // features; with noise enabled, also add extra features, cut the weight
    // stream short or throw in a burst of random beats.
    task automatic run_layer(input bit noisy);
        int unsigned n_feat;
        int unsigned n_wt;
        // A short feature load is only safe when every position a weight
        // can touch already holds a written feature.
        n_feat = eff_in;
        if (stored_hi >= eff_in && $urandom_range(7) == 0)
            n_feat = $urandom_range(eff_in - 1);
        for (int i = 0; i < n_feat; i++)
            send_beat(OP_FEATURE, pick_sample(), SAMPLE_W'($urandom));
        if (n_feat > stored_hi) stored_hi = n_feat;

        if (noisy && n_feat == eff_in && $urandom_range(5) == 0) begin
            for (int i = 0; i <= $urandom_range(2); i++)
                send_beat(OP_FEATURE, pick_sample(), SAMPLE_W'($urandom));
        end

        n_wt = eff_in * eff_out;
        if (noisy && $urandom_range(9) == 0) n_wt = $urandom_range(n_wt);
        for (int i = 0; i < n_wt; i++)
            send_beat(OP_WEIGHT, pick_sample(), SAMPLE_W'($urandom));

        if (noisy && $urandom_range(5) == 0) begin
            for (int i = 0; i <= $urandom_range(3); i++)
                send_beat(logic'($urandom_range(1)), pick_sample(), SAMPLE_W'($urandom));
        end

        // Now and then hold off until the block has drained completely.
        if ($urandom_range(19) == 0) settle();
    endtask

    // Reprogram the layer, pick the idle pattern and stream layers until the
    // beat budget is spent.
    task automatic run_phase(input int unsigned num_in, input int unsigned num_out,
                             input int unsigned shift, input int unsigned budget,
                             input int idle_mode);
        int unsigned start;
        settle();
        program_layer(num_in, num_out, shift);
        case (idle_mode)
            0:       begin tx_idle_pct = 38; rx_idle_pct = 53; end
            1:       begin tx_idle_pct = 53; rx_idle_pct = 38; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        endcase
        start = items_sent;
        do
            run_layer(eff_in * eff_out <= 64);
        while (items_sent - start < budget);
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: registers at reset values (one input, one unit, no shift).
        send_beat(OP_FEATURE, 16'sh8000, 16'sh0000);
        send_beat(OP_FEATURE, 16'sh7FFF, 16'sh0000);   // extra feature, dropped
        send_beat(OP_WEIGHT,  16'sh8000, 16'sh7FFF);
        send_beat(OP_WEIGHT,  16'sh0001, 16'sh8000);   // weight on a stale feature
        send_beat(OP_FEATURE, 16'sh7FFF, 16'sh1234);
        send_beat(OP_WEIGHT,  16'sh7FFF, 16'sh0000);

        // Two inputs, unit count of zero, full shift: the sum wraps to the
        // most negative value and shifts down to -1.
        settle();
        program_layer(2, 0, 31);
        send_beat(OP_FEATURE, 16'sh8000, 16'sh0000);
        send_beat(OP_FEATURE, 16'sh8000, 16'sh0000);
        send_beat(OP_WEIGHT,  16'sh8000, 16'sh5A5A);   // bias ignored mid-row
        send_beat(OP_WEIGHT,  16'sh8000, 16'shFFFF);

        // Three units of one input each, mid-range shift.
        settle();
        program_layer(1, 3, 16);
        send_beat(OP_FEATURE, 16'sh5555, 16'sh0000);
        send_beat(OP_WEIGHT,  16'sh7FFF, 16'sh5555);
        send_beat(OP_WEIGHT,  16'shFFFF, 16'sh2AAA);
        send_beat(OP_WEIGHT,  16'sh0000, 16'sh0000);

        // Unit count above the maximum; restart after two rows.
        settle();
        program_layer(2047, 2047, 0);
        program_layer(1, 2047, 0);
        send_beat(OP_FEATURE, 16'sh04D2, 16'sh0000);
        send_beat(OP_WEIGHT,  16'sh0001, 16'sh0000);
        send_beat(OP_WEIGHT,  16'sh0002, 16'sh0000);
        stored_hi = 2;

        // Random layers; the two largest shapes run once each.
        run_phase(4,  3,  2,  150, 0);
        run_phase(1,  5,  0,  100, 0);
        run_phase(80, 1,  13, 1,   0);
        run_phase(7,  2,  31, 150, 1);
        run_phase(0,  60, 5,  1,   1);
        run_phase(3,  4,  16, 150, 1);
        run_phase(16, 2,  9,  120, 2);
        run_phase(5,  6,  1,  100, 2);
        run_phase(2,  1,  30, 100, 2);

        settle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
